>>> hw/rtl/pip_pkg.sv
// Package for the positional insert queue.
// Holds the operation and status codes and the default capacity.
// No dependencies; every other file of the block imports it.
package pip_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned IdWidth     = 32;
  localparam int unsigned PosWidth    = 16;
  localparam int unsigned OccWidth    = 5;

  typedef enum logic [1:0] {
    MODE_FRONT  = 2'd0,
    MODE_BACK   = 2'd1,
    MODE_AT     = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
  } pip_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic full;
  } pip_stat_t;

endpackage

>>> hw/rtl/pip_ctrl.sv
// Controller of the positional insert queue.
// Tracks whether a result is pending and issues the load command.
// Depends on pip_pkg.
module pip_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  pip_pkg::pip_stat_t stat_i,
  output pip_pkg::pip_cmd_t  cmd_o
);
  import pip_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   load;

  // A new request may enter in the same cycle that the pending result leaves.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign load        = in_valid_i && !in_stall_o;
  assign cmd_o.load  = load;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (load) begin
            state_q     <= S_HOLD;
            out_valid_q <= 1'b1;
          end
        end
        S_HOLD: begin
          if (load) begin
            state_q     <= S_HOLD;
            out_valid_q <= 1'b1;
          end else if (!out_stall_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_load_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_o)
    else $error("load did not produce a result");
  a_stall_only_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && state_q == S_HOLD))
    else $error("input stalled with no pending result");
  a_not_full_and_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat_i.full && stat_i.empty))
    else $error("queue reported full and empty at once");
`endif

endmodule

>>> hw/rtl/pip_dpath.sv
// Datapath of the positional insert queue: a row of shift cells, the
// entry counter and the result registers. Every cell picks its next value
// locally, so the whole row updates at once. Depends on pip_pkg.
module pip_dpath #(
  parameter int unsigned CAPACITY = pip_pkg::DefCapacity
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pip_pkg::pip_cmd_t                    cmd_i,
  input  logic [1:0]                           mode_i,
  input  logic signed [pip_pkg::IdWidth-1:0]   entry_id_i,
  input  logic signed [pip_pkg::PosWidth-1:0]  position_i,
  output pip_pkg::pip_stat_t                   stat_o,
  output logic [1:0]                           status_o,
  output logic signed [pip_pkg::IdWidth-1:0]   removed_id_o,
  output logic [pip_pkg::OccWidth-1:0]         occupancy_o
);
  import pip_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [IdWidth-1:0]  cell_q [CAPACITY];
  logic [CntW-1:0]     count_q, count_d;
  logic [1:0]          status_q, status_d;
  logic [IdWidth-1:0]  removed_q, removed_d;

  logic                is_full, is_empty, pos_bad;
  logic                do_insert, do_remove;
  logic [PosWidth-1:0] pos_m1, count_ext;
  logic [CntW-1:0]     ins_idx;

  assign is_full   = (count_q == CntW'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign pos_bad   = position_i[PosWidth-1] || (position_i == '0);
  assign pos_m1    = PosWidth'($unsigned(position_i)) - PosWidth'(1);
  assign count_ext = PosWidth'(count_q);

  // A position past the current length appends at the back.
  always_comb begin
    case (mode_i)
      MODE_FRONT: ins_idx = '0;
      MODE_BACK:  ins_idx = count_q;
      default:    ins_idx = (pos_m1 >= count_ext) ? count_q : CntW'(pos_m1);
    endcase
  end

  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    status_d  = STAT_OK;
    if (mode_i == MODE_REMOVE) begin
      if (is_empty) begin
        status_d = STAT_EMPTY;
      end else begin
        do_remove = 1'b1;
      end
    end else if (mode_i == MODE_AT && pos_bad) begin
      status_d = STAT_BADPOS;
    end else if (is_full) begin
      status_d = STAT_FULL;
    end else begin
      do_insert = 1'b1;
    end
  end

  assign removed_d = do_remove ? cell_q[0] : '0;

  always_comb begin
    count_d = count_q;
    if (cmd_i.load && do_insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.load && do_remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  // On a remove, cell k takes its right neighbor (the last cell keeps its value);
  // on an insert it takes the new identifier, its left neighbor, or keeps its value.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam logic [CntW-1:0] KIdx = CntW'(k);
    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        if (do_remove) begin
          if (k < CAPACITY - 1) begin
            cell_q[k] <= cell_q[(k < CAPACITY - 1) ? k + 1 : k];
          end
        end else if (do_insert) begin
          if (KIdx == ins_idx) begin
            cell_q[k] <= entry_id_i;
          end else if (k > 0 && KIdx > ins_idx) begin
            cell_q[k] <= cell_q[(k > 0) ? k - 1 : k];
          end
        end
      end
    end
  end

  assign stat_o.empty  = is_empty;
  assign stat_o.full   = is_full;
  assign status_o      = status_q;
  assign removed_id_o  = removed_q;
  assign occupancy_o   = OccWidth'(count_q);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load |=> $stable(count_q))
    else $error("entry count changed without a request");
  a_full_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && is_full && mode_i != MODE_REMOVE && !pos_bad)
      |=> (status_q == STAT_FULL && $stable(count_q)))
    else $error("insert into a full queue was not rejected");
`endif

endmodule

>>> hw/rtl/positional_insert_queue_top.sv
// Positional insert queue: an ordered queue of 32-bit identifiers.
//
// Input channel (in_valid_i / in_stall_o) carries one request: mode_i selects
// insert front, insert back, insert at the 1-based position_i, or remove the
// front entry; entry_id_i is the identifier to insert.
// Output channel (out_valid_o / out_stall_i) returns one result per request:
// status_o, removed_id_o (zero unless a remove succeeded) and occupancy_o,
// the entry count after the operation.
// Latency: the result is valid in the cycle after the request is taken.
// Throughput: one request per cycle while out_stall_i is low. The shift cells
// settle any operation at once, and a new request may enter while the previous
// result leaves. While the receiver stalls, the result holds and in_stall_o is
// high, so at most one result is ever pending.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending
// result; the cell contents are not cleared and are never read before they
// are written. Depends on pip_pkg, pip_ctrl and pip_dpath.
module positional_insert_queue_top #(
  parameter int unsigned CAPACITY = pip_pkg::DefCapacity
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           mode_i,
  input  logic signed [pip_pkg::IdWidth-1:0]   entry_id_i,
  input  logic signed [pip_pkg::PosWidth-1:0]  position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic signed [pip_pkg::IdWidth-1:0]   removed_id_o,
  output logic [pip_pkg::OccWidth-1:0]         occupancy_o
);
  import pip_pkg::*;

  pip_cmd_t  cmd;
  pip_stat_t stat;

  pip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pip_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (mode_i),
    .entry_id_i   (entry_id_i),
    .position_i   (position_i),
    .stat_o       (stat),
    .status_o     (status_o),
    .removed_id_o (removed_id_o),
    .occupancy_o  (occupancy_o)
  );

endmodule
